>>> rtl/mdq_pkg.sv
// Shared types, constants and helpers for the message descriptor queue.
// Used by message_descriptor_queue and its bench; depends on nothing.
package mdq_pkg;

	localparam int QUEUE_SLOTS = 128;
	localparam int BUF_BYTES   = 4096;

	localparam int SLOT_W  = $clog2(QUEUE_SLOTS);
	localparam int BADDR_W = $clog2(BUF_BYTES);
	localparam int OFS_W   = BADDR_W + 1;
	localparam int SIZE_W  = 13;
	localparam int TYPE_W  = 8;
	localparam int OFFS_W  = 12;
	localparam int BYTE_W  = 8;
	localparam int SUM_W   = ((OFS_W > SIZE_W) ? OFS_W : SIZE_W) + 1;
	localparam int RESET_BUFFER_SIZE = 4096;

	typedef enum logic [1:0] {
		MODE_PUSH = 2'd0,
		MODE_PEEK = 2'd1,
		MODE_POP  = 2'd2,
		MODE_READ = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_OVERSIZE = 2'd2
	} status_t;

	typedef struct packed {
		mode_t               mode;
		logic                first;
		logic [SIZE_W-1:0]   msg_size;
		logic [TYPE_W-1:0]   msg_type;
		logic [BYTE_W-1:0]   data_byte;
		logic [OFFS_W-1:0]   byte_index;
	} in_beat_t;

	typedef struct packed {
		status_t             status;
		logic                is_empty;
		logic                has_room;
		logic [SIZE_W-1:0]   head_size;
		logic [TYPE_W-1:0]   head_type;
		logic [OFFS_W-1:0]   head_offset;
		logic [BYTE_W-1:0]   read_byte;
	} out_beat_t;

	typedef struct packed {
		logic [SIZE_W-1:0]   size;
		logic [TYPE_W-1:0]   kind;
		logic [OFFS_W-1:0]   offset;
	} desc_t;

	localparam int DESC_W = $bits(desc_t);

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

endpackage

>>> rtl/mdq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds its value until the next read. No dependencies.
module mdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/message_descriptor_queue.sv
// Top level of the message descriptor queue: ring pointers, push control and
// the result register. Depends on mdq_pkg and two mdq_ram instances.
//
//   channel   direction  handshake               beat
//   in        in         in_valid / in_stall     in_beat  (mdq_pkg::in_beat_t)
//   out       out        out_valid / out_stall   out_beat (mdq_pkg::out_beat_t)
//   cfg       in         cfg_we                  cfg_wdata (buffer_size)
//
// Each item passes through acceptance with all writes, descriptor RAM read,
// byte RAM read from the fetched head offset, and the load of the result.
// The byte read depends on the offset fetched by the descriptor read.
// in_stall is high from acceptance until the result is loaded.
// A stalled result waits in the output register while the next item is taken;
// the following result is held back until that register is free.
// Reset clears the pointers and sets buffer_size to 4096; the RAMs are not cleared.
module message_descriptor_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mdq_pkg::in_beat_t   in_beat,
	output logic                out_valid,
	input  logic                out_stall,
	output mdq_pkg::out_beat_t  out_beat,
	input  logic                cfg_we,
	input  logic [12:0]         cfg_wdata
);

	import mdq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DRD  = 4'b0010,
		ST_DWT  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [SLOT_W-1:0]   head_q, head_d;
	logic [SLOT_W-1:0]   tail_q, tail_d;
	logic [OFS_W-1:0]    wo_q, wo_d;
	logic [SIZE_W-1:0]   bw_q, bw_d;
	logic                act_q, act_d;
	logic [SIZE_W-1:0]   buffer_size_q;
	logic [SIZE_W-1:0]   cur_size_q;
	mode_t               mode_q;
	logic [OFFS_W-1:0]   idx_q;
	status_t             status_q, status_d;
	logic                out_valid_q;
	out_beat_t           out_q;

	logic                accept;
	logic                load;
	logic                empty;
	logic [SUM_W-1:0]    lim_ext;
	logic [SUM_W-1:0]    size_ext;
	logic [OFS_W-1:0]    ofs_sel;
	logic                st_en;
	logic [OFS_W-1:0]    st_ofs;
	logic [SIZE_W-1:0]   st_cnt;
	logic [SIZE_W-1:0]   st_size;
	logic [SIZE_W-1:0]   st_next;
	logic                desc_we;
	desc_t               desc_wdata;
	desc_t               desc_rdata;
	logic                byte_we;
	logic [BADDR_W-1:0]  byte_waddr;
	logic                byte_re;
	logic [OFFS_W:0]     rd_sum;
	logic [BYTE_W-1:0]   byte_rdata;

	assign accept    = (state_q == ST_IDLE) && in_valid;
	assign in_stall  = (state_q != ST_IDLE);
	assign load      = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign empty     = (head_q == tail_q);
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	assign lim_ext  = (SUM_W'(buffer_size_q) > SUM_W'(BUF_BYTES)) ?
		SUM_W'(BUF_BYTES) : SUM_W'(buffer_size_q);
	assign size_ext = SUM_W'(in_beat.msg_size);

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		wo_d       = wo_q;
		bw_d       = bw_q;
		act_d      = act_q;
		status_d   = STATUS_OK;
		ofs_sel    = wo_q;
		st_en      = 1'b0;
		st_ofs     = wo_q;
		st_cnt     = bw_q;
		st_size    = cur_size_q;
		st_next    = '0;
		desc_we    = 1'b0;
		desc_wdata = '0;
		byte_we    = 1'b0;
		byte_waddr = '0;
		if (accept) begin
			case (in_beat.mode)
				MODE_PUSH: begin
					if (in_beat.first) begin
						act_d = 1'b0;
						if (next_slot(tail_q) == head_q) begin
							status_d = STATUS_FULL;
						end else if (size_ext > lim_ext) begin
							status_d = STATUS_OVERSIZE;
						end else begin
							if (SUM_W'(wo_q) + size_ext > lim_ext) begin
								ofs_sel = '0;
							end
							wo_d       = ofs_sel;
							desc_we    = 1'b1;
							desc_wdata = '{size: in_beat.msg_size, kind: in_beat.msg_type,
								offset: OFFS_W'(ofs_sel)};
							bw_d       = '0;
							if (in_beat.msg_size == '0) begin
								tail_d = next_slot(tail_q);
							end else begin
								act_d   = 1'b1;
								st_en   = 1'b1;
								st_ofs  = ofs_sel;
								st_cnt  = '0;
								st_size = in_beat.msg_size;
							end
						end
					end else if (act_q) begin
						st_en = 1'b1;
					end
				end
				MODE_POP: begin
					if (!empty) begin
						head_d = next_slot(head_q);
					end
				end
				default: begin
				end
			endcase
		end
		if (st_en) begin
			byte_we    = (st_ofs < OFS_W'(BUF_BYTES));
			byte_waddr = BADDR_W'(st_ofs);
			wo_d       = st_ofs + 1'b1;
			st_next    = st_cnt + 1'b1;
			bw_d       = st_next;
			if (st_next >= st_size) begin
				tail_d = next_slot(tail_q);
				act_d  = 1'b0;
			end
		end
	end

	assign byte_re = (state_q == ST_DWT) && (mode_q == MODE_READ) && !empty;
	assign rd_sum  = {1'b0, desc_rdata.offset} + {1'b0, idx_q};

	mdq_ram #(
		.WIDTH(DESC_W),
		.DEPTH(QUEUE_SLOTS)
	) u_desc_ram (
		.clk  (clk),
		.we   (desc_we),
		.waddr(tail_q),
		.wdata(desc_wdata),
		.re   (state_q == ST_DRD),
		.raddr(head_q),
		.rdata(desc_rdata)
	);

	mdq_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUF_BYTES)
	) u_byte_ram (
		.clk  (clk),
		.we   (byte_we),
		.waddr(byte_waddr),
		.wdata(in_beat.data_byte),
		.re   (byte_re),
		.raddr(BADDR_W'(rd_sum)),
		.rdata(byte_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			head_q        <= '0;
			tail_q        <= '0;
			wo_q          <= '0;
			bw_q          <= '0;
			act_q         <= 1'b0;
			buffer_size_q <= SIZE_W'(RESET_BUFFER_SIZE);
			out_valid_q   <= 1'b0;
		end else begin
			head_q      <= head_d;
			tail_q      <= tail_d;
			wo_q        <= wo_d;
			bw_q        <= bw_d;
			act_q       <= act_d;
			out_valid_q <= load || (out_valid_q && out_stall);
			if (cfg_we) begin
				buffer_size_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DRD;
					end
				end
				ST_DRD: begin
					state_q <= ST_DWT;
				end
				ST_DWT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= in_beat.mode;
			idx_q    <= in_beat.byte_index;
			status_q <= status_d;
		end
		if (accept && in_beat.mode == MODE_PUSH && in_beat.first) begin
			cur_size_q <= in_beat.msg_size;
		end
		if (load) begin
			out_q.status      <= status_q;
			out_q.is_empty    <= empty;
			out_q.has_room    <= (next_slot(tail_q) != head_q);
			out_q.head_size   <= empty ? '0 : desc_rdata.size;
			out_q.head_type   <= empty ? '0 : desc_rdata.kind;
			out_q.head_offset <= empty ? '0 : desc_rdata.offset;
			out_q.read_byte   <= (mode_q == MODE_READ && !empty) ? byte_rdata : '0;
		end
	end

	a_accept_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_DRD)
		else $error("accepted item did not start the descriptor read");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> bw_q < cur_size_q)
		else $error("active push has already stored its full size");

	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wo_q <= OFS_W'(BUF_BYTES))
		else $error("write offset ran past the byte buffer");

	a_status_push: assert property (@(posedge clk) disable iff (!arst_n)
		load && status_q != STATUS_OK |-> mode_q == MODE_PUSH)
		else $error("rejection status on a non-push item");

	a_fin_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> $past(state_q) == ST_DWT || $past(state_q) == ST_FIN)
		else $error("result stage entered without a descriptor read");

endmodule

>>> bench/message_descriptor_queue_test.sv
// Self-checking bench for message_descriptor_queue: predicts every result beat
// from its own model of the descriptor ring and byte buffer and compares fields.
// Depends on mdq_pkg and the message_descriptor_queue RTL.
`timescale 1ns / 1ps

module message_descriptor_queue_test;
	import mdq_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_beat = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_beat;
	logic cfg_we = 1'b0;
	logic [12:0] cfg_wdata = '0;

	message_descriptor_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_beat(in_beat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_beat(out_beat),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	in_beat_t beats_to_send[$];
	out_beat_t outcomes_due[$];
	int unsigned issued = 0;
	int unsigned errors = 0;
	int unsigned send_idle = 0;
	int unsigned recv_stall = 0;

	logic [SLOT_W-1:0] rd_slot = '0;
	logic [SLOT_W-1:0] wr_slot = '0;
	int unsigned wr_ofs = 0;
	int unsigned msg_fill = 0;
	logic msg_open = 1'b0;
	int unsigned buf_limit = RESET_BUFFER_SIZE;
	logic [SIZE_W-1:0] ring_size[QUEUE_SLOTS];
	logic [TYPE_W-1:0] ring_kind[QUEUE_SLOTS];
	logic [OFFS_W-1:0] ring_ofs[QUEUE_SLOTS];
	logic [BYTE_W-1:0] byte_mem[BUF_BYTES];
	bit byte_seen[BUF_BYTES];
	int unsigned seen_addrs[$];

	function automatic logic [SLOT_W-1:0] ring_next(logic [SLOT_W-1:0] s);
		return (int'(s) == QUEUE_SLOTS - 1) ? '0 : s + 1'b1;
	endfunction

	function automatic void store_byte(logic [BYTE_W-1:0] d);
		if (wr_ofs < BUF_BYTES) begin
			byte_mem[wr_ofs] = d;
			if (!byte_seen[wr_ofs]) begin
				byte_seen[wr_ofs] = 1'b1;
				seen_addrs.push_back(wr_ofs);
			end
		end
		wr_ofs++;
		msg_fill++;
		if (msg_fill >= ring_size[wr_slot]) begin
			wr_slot = ring_next(wr_slot);
			msg_open = 1'b0;
		end
	endfunction

	function automatic status_t push_byte(in_beat_t b);
		int unsigned sz = b.msg_size;
		if (!b.first) begin
			if (msg_open)
				store_byte(b.data_byte);
			return STATUS_OK;
		end
		msg_open = 1'b0;
		if (ring_next(wr_slot) == rd_slot)
			return STATUS_FULL;
		if (sz > buf_limit)
			return STATUS_OVERSIZE;
		if (wr_ofs + sz > buf_limit)
			wr_ofs = 0;
		ring_size[wr_slot] = b.msg_size;
		ring_kind[wr_slot] = b.msg_type;
		ring_ofs[wr_slot] = OFFS_W'(wr_ofs);
		msg_fill = 0;
		if (sz == 0) begin
			wr_slot = ring_next(wr_slot);
			return STATUS_OK;
		end
		msg_open = 1'b1;
		store_byte(b.data_byte);
		return STATUS_OK;
	endfunction

	function automatic out_beat_t queue_outcome(in_beat_t b);
		out_beat_t r;
		status_t st = STATUS_OK;
		logic [BYTE_W-1:0] rb = '0;
		logic [OFFS_W-1:0] addr;
		logic empty;
		case (b.mode)
			MODE_PUSH: st = push_byte(b);
			MODE_PEEK: ;
			MODE_POP: if (rd_slot != wr_slot) rd_slot = ring_next(rd_slot);
			MODE_READ: begin
				if (rd_slot != wr_slot) begin
					addr = ring_ofs[rd_slot] + b.byte_index;
					rb = byte_mem[addr];
				end
			end
		endcase
		empty = (rd_slot == wr_slot);
		r.status = st;
		r.is_empty = empty;
		r.has_room = (ring_next(wr_slot) != rd_slot);
		r.head_size = empty ? '0 : ring_size[rd_slot];
		r.head_type = empty ? '0 : ring_kind[rd_slot];
		r.head_offset = empty ? '0 : ring_ofs[rd_slot];
		r.read_byte = rb;
		return r;
	endfunction

	task automatic issue(in_beat_t b);
		outcomes_due.push_back(queue_outcome(b));
		beats_to_send.push_back(b);
		issued++;
	endtask

	function automatic in_beat_t mk(mode_t m, logic f, int unsigned sz, int unsigned ty,
			int unsigned d, int unsigned idx);
		in_beat_t b;
		b.mode = m;
		b.first = f;
		b.msg_size = SIZE_W'(sz);
		b.msg_type = TYPE_W'(ty);
		b.data_byte = BYTE_W'(d);
		b.byte_index = OFFS_W'(idx);
		return b;
	endfunction

	function automatic in_beat_t rand_beat(mode_t m);
		return mk(m, 1'($urandom_range(0, 1)), $urandom_range(0, BUF_BYTES), $urandom,
			$urandom, $urandom);
	endfunction

	task automatic send_message(int unsigned sz, int unsigned tail_bytes);
		in_beat_t b = rand_beat(MODE_PUSH);
		b.first = 1'b1;
		b.msg_size = SIZE_W'(sz);
		issue(b);
		repeat (tail_bytes) begin
			b = rand_beat(MODE_PUSH);
			b.first = 1'b0;
			issue(b);
		end
	endtask

	// Reads pick an index inside the head message, or else a byte that has been stored at least once.
	task automatic read_head();
		in_beat_t b = rand_beat(MODE_READ);
		int unsigned pick;
		if (rd_slot != wr_slot) begin
			if (ring_size[rd_slot] != 0 && $urandom_range(0, 99) < 70) begin
				b.byte_index = OFFS_W'($urandom_range(0, ring_size[rd_slot] - 1));
			end else if (seen_addrs.size() != 0) begin
				pick = seen_addrs[$urandom_range(0, seen_addrs.size() - 1)];
				b.byte_index = OFFS_W'(pick - ring_ofs[rd_slot]);
			end else begin
				b.mode = MODE_PEEK;
			end
		end
		issue(b);
	endtask

	function automatic int unsigned pick_size();
		int unsigned r = $urandom_range(0, 99);
		int unsigned cap;
		if (r < 5 && buf_limit < BUF_BYTES)
			return $urandom_range(buf_limit + 1, BUF_BYTES);
		cap = (r < 45) ? 4 : (r < 85) ? 16 : (r < 98) ? 64 : 300;
		if (cap > buf_limit)
			cap = buf_limit;
		return $urandom_range(0, cap);
	endfunction

	task automatic random_step();
		int unsigned r = $urandom_range(0, 99);
		int unsigned sz;
		in_beat_t b;
		if (r < 40) begin
			sz = pick_size();
			send_message(sz, (sz == 0 || sz > buf_limit) ? 0 : sz - 1);
		end else if (r < 45) begin
			b = rand_beat(MODE_PUSH);
			b.first = 1'b0;
			issue(b);
		end else if (r < 50 && buf_limit >= 2) begin
			sz = $urandom_range(2, (buf_limit < 32) ? buf_limit : 32);
			send_message(sz, $urandom_range(0, sz - 2));
		end else if (r < 70) begin
			issue(rand_beat(MODE_POP));
		end else if (r < 78) begin
			issue(rand_beat(MODE_PEEK));
		end else begin
			read_head();
		end
	endtask

	task automatic settle();
		while (beats_to_send.size() != 0 || outcomes_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_buffer_size(int unsigned v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 13'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		buf_limit = (v > BUF_BYTES) ? BUF_BYTES : v;
	endtask

	task automatic flag(string what, logic [15:0] want, logic [15:0] got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_beat <= '0;
		end else if (!in_valid || !in_stall) begin
			if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				in_beat <= beats_to_send.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (outcomes_due.size() == 0) begin
					flag("result beat with nothing outstanding", 0, 0);
				end else begin
					want = outcomes_due.pop_front();
					if (out_beat.status !== want.status)
						flag("status", want.status, out_beat.status);
					if (out_beat.is_empty !== want.is_empty)
						flag("is_empty", want.is_empty, out_beat.is_empty);
					if (out_beat.has_room !== want.has_room)
						flag("has_room", want.has_room, out_beat.has_room);
					if (out_beat.head_size !== want.head_size)
						flag("head_size", want.head_size, out_beat.head_size);
					if (out_beat.head_type !== want.head_type)
						flag("head_type", want.head_type, out_beat.head_type);
					if (out_beat.head_offset !== want.head_offset)
						flag("head_offset", want.head_offset, out_beat.head_offset);
					if (out_beat.read_byte !== want.read_byte)
						flag("read_byte", want.read_byte, out_beat.read_byte);
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall);
		end
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int unsigned cfg_plan[6] = '{4096, 1, 16, 200, 0, 4095};
		int unsigned item_plan[6] = '{90, 70, 200, 90, 90, 70};
		int unsigned idle_plan[6] = '{55, 0, 0, 33, 55, 0};
		int unsigned stall_plan[6] = '{0, 55, 0, 33, 0, 55};
		int unsigned v;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(mk(MODE_PEEK, 1'b0, 0, 0, 0, 0));
		issue(mk(MODE_POP, 1'b0, 0, 0, 0, 0));
		issue(mk(MODE_READ, 1'b1, 4096, 255, 255, 4095));
		issue(mk(MODE_PUSH, 1'b0, 4096, 255, 255, 4095));
		issue(mk(MODE_PUSH, 1'b1, 3, 255, 0, 0));
		issue(mk(MODE_PUSH, 1'b0, 0, 0, 255, 0));
		issue(mk(MODE_PUSH, 1'b0, 0, 0, 8'h5A, 0));
		issue(mk(MODE_PUSH, 1'b1, 0, 0, 255, 0));
		issue(mk(MODE_PUSH, 1'b1, 4096, 8'h80, 8'h11, 0));
		issue(mk(MODE_PUSH, 1'b0, 0, 0, 8'h22, 0));
		issue(mk(MODE_PUSH, 1'b1, 2, 8'h01, 8'h33, 0));
		issue(mk(MODE_PUSH, 1'b0, 0, 0, 8'h44, 0));
		issue(mk(MODE_PEEK, 1'b0, 0, 0, 0, 0));
		issue(mk(MODE_READ, 1'b0, 0, 0, 0, 0));
		issue(mk(MODE_READ, 1'b0, 0, 0, 0, 2));
		issue(mk(MODE_POP, 1'b0, 0, 0, 0, 0));
		issue(mk(MODE_PEEK, 1'b0, 0, 0, 0, 0));
		issue(mk(MODE_POP, 1'b0, 0, 0, 0, 0));
		issue(mk(MODE_READ, 1'b0, 0, 0, 0, 1));
		issue(mk(MODE_READ, 1'b0, 0, 0, 0, 4095));
		issue(mk(MODE_POP, 1'b0, 0, 0, 0, 0));
		issue(mk(MODE_POP, 1'b0, 0, 0, 0, 0));
		issue(mk(MODE_PEEK, 1'b0, 0, 0, 0, 0));

		for (int p = 0; p < 6; p++) begin
			settle();
			v = (cfg_plan[p] == 0) ? $urandom_range(1, 4096) : cfg_plan[p];
			set_buffer_size(v);
			send_idle = idle_plan[p];
			recv_stall = stall_plan[p];
			issued = 0;
			// Zero-size messages with no pops run the ring into its full state.
			if (p == 2) begin
				repeat (140) send_message(0, 0);
			end
			while (issued < item_plan[p])
				random_step();
		end

		settle();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
